// ----- hw/rtl/imuvd_pkg.sv -----
`default_nettype none

package imuvd_pkg;

   localparam int SAMPLE_RATE_DEFAULT = 416;

   localparam int AXES        = 3;
   localparam int ROOT_STEPS  = 24;
   localparam int RECIP_STEPS = 4;

   localparam logic [15:0] ACCEL_OFFSET_RESET = 16'd1000;
   localparam logic [15:0] VEL_THRESHOLD_RESET = 16'd10;

   localparam logic REG_ACCEL_OFFSET    = 1'b0;
   localparam logic REG_VEL_THRESHOLD   = 1'b1;

   localparam logic signed [24:0] REL_MAX = 25'sh0FF_FFFF;
   localparam logic signed [24:0] REL_MIN = -25'sh100_0000;
   localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] ACC_MIN = -48'sh7FFF_FFFF_FFFF - 48'sd1;
   localparam logic [30:0]        DIST_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [15:0] accel_offset;
      logic [15:0] velocity_threshold;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] first_x;
      logic signed [15:0] first_y;
      logic signed [15:0] first_z;
      logic signed [15:0] second_x;
      logic signed [15:0] second_y;
      logic signed [15:0] second_z;
      logic [15:0]        range_reading;
   } sample_type;

   typedef struct packed {
      logic signed [24:0] rel_accel_q8;
      logic signed [47:0] velocity_total;
      logic [30:0]        distance_estimate_q8;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/imuvd_engine.sv -----
`default_nettype none

module imuvd_engine import imuvd_pkg::*; #(
   parameter int SAMPLE_RATE = SAMPLE_RATE_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   input  wire cfg_type    cfg,
   input  wire        req_valid,
   input  wire sample_type req_sample,
   output logic       req_ready,
   output logic       res_valid,
   input  wire        res_take,
   output result_type res
);

   localparam int          RATE    = (SAMPLE_RATE < 1) ? 1 : SAMPLE_RATE;
   localparam logic [16:0] RATE_OP = 17'(RATE);
   localparam logic [31:0] RATE_W  = 32'(RATE);
   localparam logic [31:0] DIVISOR = RATE_W * RATE_W;

   // floor(n / DIVISOR) == (n * RECIP) >> RECIP_SHIFT for every n below 2^47
   localparam int          RECIP_SHIFT = 47 + $clog2(DIVISOR);
   localparam logic [95:0] RECIP_FULL  =
      ((96'd1 << RECIP_SHIFT) + 96'(DIVISOR) - 96'd1) / 96'(DIVISOR);
   localparam logic [47:0] RECIP       = RECIP_FULL[47:0];

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQ   = 4'd1;
   localparam logic [3:0] S_ROOT = 4'd2;
   localparam logic [3:0] S_REL  = 4'd3;
   localparam logic [3:0] S_ACC  = 4'd4;
   localparam logic [3:0] S_CMP  = 4'd5;
   localparam logic [3:0] S_DIV  = 4'd6;
   localparam logic [3:0] S_FIN  = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               imu_ff, imu_in;
   logic signed [15:0] axis_ff [2*AXES];
   logic signed [15:0] axis_in [2*AXES];
   logic [15:0]        range_ff, range_in;
   logic [31:0]        sum_ff, sum_in;
   logic [47:0]        work_ff, work_in;
   logic [31:0]        rem_ff, rem_in;
   logic [23:0]        root_ff, root_in;
   logic [23:0]        mag_a_ff, mag_a_in;
   logic [31:0]        thrp_ff, thrp_in;
   logic signed [24:0] rel_ff, rel_in;
   logic signed [47:0] acc_ff, acc_in;
   logic               over_ff, over_in;
   logic [95:0]        prod_ff, prod_in;
   logic [30:0]        dist_ff, dist_in;

   logic [2:0]         axis_idx;
   logic [23:0]        n_limb, m_limb;
   logic signed [24:0] mul_a, mul_b;
   logic signed [49:0] mul_p;
   logic [95:0]        part_sh;
   logic [33:0]        sub_a, sub_b;
   logic [34:0]        sub_d;
   logic               sub_ge;
   logic [31:0]        sum_next;
   logic signed [26:0] rel_wide;
   logic signed [48:0] acc_wide;
   logic [95:0]        quot_sh;
   logic [47:0]        quot;
   logic [48:0]        dist_wide;

   assign axis_idx = cnt_ff[2:0] + (imu_ff ? 3'(AXES) : 3'd0);
   assign n_limb   = cnt_ff[1] ? work_ff[47:24] : work_ff[23:0];
   assign m_limb   = cnt_ff[0] ? RECIP[47:24] : RECIP[23:0];

   // shared multiplier: axis squares, threshold * rate, reciprocal partial products
   always_comb begin
      if (state_ff == S_REL) begin
         mul_a = $signed({9'd0, cfg.velocity_threshold});
         mul_b = $signed({8'd0, RATE_OP});
      end else if (state_ff == S_DIV) begin
         mul_a = $signed({1'b0, n_limb});
         mul_b = $signed({1'b0, m_limb});
      end else begin
         mul_a = {{9{axis_ff[axis_idx][15]}}, axis_ff[axis_idx]};
         mul_b = {{9{axis_ff[axis_idx][15]}}, axis_ff[axis_idx]};
      end
   end
   assign mul_p = mul_a * mul_b;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    part_sh = {48'd0, mul_p[47:0]};
         2'd3:    part_sh = {mul_p[47:0], 48'd0};
         default: part_sh = {24'd0, mul_p[47:0], 24'd0};
      endcase
   end

   // trial subtractor: root digits
   assign sub_a  = {6'd0, rem_ff[25:0], work_ff[47:46]};
   assign sub_b  = {8'd0, root_ff, 2'b01};
   assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge = ~sub_d[34];

   assign sum_next = sum_ff + mul_p[31:0];
   assign rel_wide = $signed({3'd0, root_ff}) - $signed({3'd0, mag_a_ff})
                   - $signed({3'd0, cfg.accel_offset, 8'd0});
   assign acc_wide = {acc_ff[47], acc_ff} + {{24{rel_ff[24]}}, rel_ff};
   assign quot_sh   = prod_ff >> RECIP_SHIFT;
   assign quot      = over_ff ? quot_sh[47:0] : 48'd0;
   assign dist_wide = {25'd0, range_ff, 8'd0} + {1'b0, quot};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      imu_in   = imu_ff;
      axis_in  = axis_ff;
      range_in = range_ff;
      sum_in   = sum_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      mag_a_in = mag_a_ff;
      thrp_in  = thrp_ff;
      rel_in   = rel_ff;
      acc_in   = acc_ff;
      over_in  = over_ff;
      prod_in  = prod_ff;
      dist_in  = dist_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               axis_in[0] = req_sample.first_x;
               axis_in[1] = req_sample.first_y;
               axis_in[2] = req_sample.first_z;
               axis_in[3] = req_sample.second_x;
               axis_in[4] = req_sample.second_y;
               axis_in[5] = req_sample.second_z;
               range_in   = req_sample.range_reading;
               sum_in     = 32'd0;
               cnt_in     = 6'd0;
               imu_in     = 1'b0;
               state_in   = S_SQ;
            end
         end
         S_SQ: begin
            sum_in = sum_next;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(AXES - 1)) begin
               cnt_in   = 6'd0;
               work_in  = {sum_next, 16'd0};
               rem_in   = 32'd0;
               root_in  = 24'd0;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            root_in = {root_ff[22:0], sub_ge};
            rem_in  = sub_ge ? sub_d[31:0] : sub_a[31:0];
            work_in = {work_ff[45:0], 2'b00};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'(ROOT_STEPS - 1)) begin
               cnt_in = 6'd0;
               if (!imu_ff) begin
                  mag_a_in = {root_ff[22:0], sub_ge};
                  imu_in   = 1'b1;
                  sum_in   = 32'd0;
                  state_in = S_SQ;
               end else begin
                  state_in = S_REL;
               end
            end
         end
         S_REL: begin
            if (rel_wide > $signed({{2{REL_MAX[24]}}, REL_MAX})) begin
               rel_in = REL_MAX;
            end else if (rel_wide < $signed({{2{REL_MIN[24]}}, REL_MIN})) begin
               rel_in = REL_MIN;
            end else begin
               rel_in = rel_wide[24:0];
            end
            thrp_in  = mul_p[31:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            if (acc_wide[48] != acc_wide[47]) begin
               acc_in = acc_wide[48] ? ACC_MIN : ACC_MAX;
            end else begin
               acc_in = acc_wide[47:0];
            end
            state_in = S_CMP;
         end
         S_CMP: begin
            over_in  = acc_ff > $signed({8'd0, thrp_ff, 8'd0});
            work_in  = acc_ff;
            prod_in  = 96'd0;
            cnt_in   = 6'd0;
            state_in = over_in ? S_DIV : S_FIN;
         end
         S_DIV: begin
            prod_in = prod_ff + part_sh;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'(RECIP_STEPS - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            dist_in  = (|dist_wide[48:31]) ? DIST_MAX : dist_wide[30:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 6'd0;
         imu_ff   <= 1'b0;
         acc_ff   <= 48'sd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         imu_ff   <= imu_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff  <= axis_in;
      range_ff <= range_in;
      sum_ff   <= sum_in;
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      mag_a_ff <= mag_a_in;
      thrp_ff  <= thrp_in;
      rel_ff   <= rel_in;
      over_ff  <= over_in;
      prod_ff  <= prod_in;
      dist_ff  <= dist_in;
   end

   assign res.rel_accel_q8         = rel_ff;
   assign res.velocity_total       = acc_ff;
   assign res.distance_estimate_q8 = dist_ff;

   a_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=>
         (state_ff == S_SQ && cnt_ff == 6'd0 && sum_ff == 32'd0))
      else $error("request not started cleanly");

   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT) |-> (rem_ff <= {7'd0, root_ff, 1'b0}))
      else $error("root remainder out of bound");

   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (over_ff && cnt_ff < 6'(RECIP_STEPS)))
      else $error("reciprocal step counter overrun");

   a_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT) |-> (cnt_ff < 6'(ROOT_STEPS)))
      else $error("step counter overrun");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_take) |=>
         (res_valid && $stable(acc_ff) && $stable(dist_ff) && $stable(rel_ff)))
      else $error("result changed while waiting");

endmodule

`default_nettype wire

// ----- hw/rtl/dual_imu_velocity_distance_estimator_top.sv -----
// channel  | direction | handshake              | payload
// req      | in        | req_tvalid/req_tready  | req_tdata: 7 x 16-bit sample fields
// rsp      | out       | rsp_tvalid/rsp_tready  | rsp_tdata: rel accel, velocity, distance
// csr      | in        | APB, pready tied high  | accel_offset @0x0, velocity_threshold @0x4
//
// A request runs S_SQ and S_ROOT per IMU, then S_REL, S_ACC, S_CMP, S_DIV when the
// distance is extrapolated, and S_FIN; the two 24-step square roots run on one shared
// trial subtractor, the axis squares, the threshold product and the 4-step reciprocal
// multiply for the division by SAMPLE_RATE squared on one 25x25 multiplier.
// Synchronous reset clears the accumulator and restores register defaults.
// A new request is taken once the previous result has moved to the output
// register; a stalled rsp holds the engine in its final state.
`default_nettype none

module dual_imu_velocity_distance_estimator_top import imuvd_pkg::*; #(
   parameter int SAMPLE_RATE = SAMPLE_RATE_DEFAULT
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z, range_reading
   input  wire  [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // rel_accel_q8 [24:0], velocity_total [72:25], distance_estimate_q8 [103:73]
   output logic [103:0] rsp_tdata,
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [2:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cfg_type     cfg_ff, cfg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;
   sample_type  sample;
   result_type  res;
   logic        res_valid;
   logic        res_take;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_ACCEL_OFFSET:  cfg_in.accel_offset       = csr_pwdata[15:0];
            REG_VEL_THRESHOLD: cfg_in.velocity_threshold = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_ACCEL_OFFSET:  csr_prdata = {16'd0, cfg_ff.accel_offset};
         REG_VEL_THRESHOLD: csr_prdata = {16'd0, cfg_ff.velocity_threshold};
         default:           csr_prdata = 32'd0;
      endcase
   end

   assign sample.first_x       = req_tdata[15:0];
   assign sample.first_y       = req_tdata[31:16];
   assign sample.first_z       = req_tdata[47:32];
   assign sample.second_x      = req_tdata[63:48];
   assign sample.second_y      = req_tdata[79:64];
   assign sample.second_z      = req_tdata[95:80];
   assign sample.range_reading = req_tdata[111:96];

   imuvd_engine #(
      .SAMPLE_RATE (SAMPLE_RATE)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_tvalid),
      .req_sample (sample),
      .req_ready  (req_tready),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res        (res)
   );

   assign res_take     = res_valid & (~rsp_valid_ff | rsp_tready);
   assign rsp_valid_in = res_take | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_offset       <= ACCEL_OFFSET_RESET;
         cfg_ff.velocity_threshold <= VEL_THRESHOLD_RESET;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.distance_estimate_q8,
                        rsp_data_ff.velocity_total,
                        rsp_data_ff.rel_accel_q8};

endmodule

`default_nettype wire
